FILE: design/aes_pkg.sv
// Shared definitions for the auto exposure search block: field codes, fixed
// constants, the microcode types and the read-only control program.
// No dependencies.
`timescale 1ns / 1ps

package aes_pkg;

    // Input function codes.
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_RESULT = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_SCAN    = 2'd0;
    localparam logic [1:0] KIND_FINAL   = 2'd1;
    localparam logic [1:0] KIND_IGNORED = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_EXPOSURE = 2'd0;
    localparam logic [1:0] CFG_MIN_EXPOSURE = 2'd1;
    localparam logic [1:0] CFG_TARGET_FRAC  = 2'd2;

    // Register reset values.
    localparam logic [15:0] MAX_EXPOSURE_RST = 16'd10000;
    localparam logic [15:0] MIN_EXPOSURE_RST = 16'd10;
    localparam logic [10:0] TARGET_FRAC_RST  = 11'd717;

    // Scan times and limits in milliseconds; DIM_PEAK is a peak level.
    localparam logic [15:0] TEST_SHORT = 16'd24;
    localparam logic [15:0] TEST_LONG  = 16'd300;
    localparam logic [15:0] FAIL_TIME  = 16'd20;
    localparam logic [16:0] CLOSE_MS   = 17'd5;
    localparam logic [15:0] DIM_PEAK   = 16'd200;

    // Window test: 100 * peak against percentages of full scale.
    localparam int          LOW_PCT   = 30;
    localparam int          HIGH_PCT  = 90;
    localparam int          PK_W      = 23;
    localparam logic [PK_W-1:0] PCT_SCALE = 23'd100;

    // Fixed-point fraction scale is 1/1024, so ten bits.
    localparam int FRAC_BITS = 10;

    // Datapath operations driven by one control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_START,
        OP_IGNORE,
        OP_TEST,
        OP_SEARCH,
        OP_TRIAL,
        OP_SAT_MAX,
        OP_PREP,
        OP_MUL1,
        OP_MUL2,
        OP_DIV_GO,
        OP_FINISH,
        OP_EMIT
    } t_op;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_START,
        C_PH_IDLE,
        C_PH_TEST,
        C_CONT,
        C_C_NONPOS,
        C_DIV_BUSY
    } t_cond;

    typedef logic [4:0] t_addr;

    // Step addresses of the control program.
    localparam t_addr A_WAIT     = 5'd0;
    localparam t_addr A_DISPATCH = 5'd1;
    localparam t_addr A_CHK_IDLE = 5'd2;
    localparam t_addr A_CHK_TEST = 5'd3;
    localparam t_addr A_SEARCH   = 5'd4;
    localparam t_addr A_CHK_CONT = 5'd5;
    localparam t_addr A_PREP     = 5'd6;
    localparam t_addr A_CHK_DIV  = 5'd7;
    localparam t_addr A_MUL1     = 5'd8;
    localparam t_addr A_MUL2     = 5'd9;
    localparam t_addr A_DIV_GO   = 5'd10;
    localparam t_addr A_DIV_WAIT = 5'd11;
    localparam t_addr A_FINISH   = 5'd12;
    localparam t_addr A_EMIT     = 5'd13;
    localparam t_addr A_START    = 5'd14;
    localparam t_addr A_IGNORE   = 5'd15;
    localparam t_addr A_TEST     = 5'd16;
    localparam t_addr A_TRIAL    = 5'd17;
    localparam t_addr A_SAT_MAX  = 5'd18;

    // One control word: operation, jump condition and jump target.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_addr target;
    } t_uword;

    // The control program. A step whose condition is false falls through.
    function automatic t_uword aes_rom(input t_addr addr);
        t_uword w;
        begin
            case (addr)
                A_WAIT:     w = '{op: OP_NOP,     cond: C_NO_INPUT, target: A_WAIT};
                A_DISPATCH: w = '{op: OP_NOP,     cond: C_START,    target: A_START};
                A_CHK_IDLE: w = '{op: OP_NOP,     cond: C_PH_IDLE,  target: A_IGNORE};
                A_CHK_TEST: w = '{op: OP_NOP,     cond: C_PH_TEST,  target: A_TEST};
                A_SEARCH:   w = '{op: OP_SEARCH,  cond: C_NEVER,    target: A_WAIT};
                A_CHK_CONT: w = '{op: OP_NOP,     cond: C_CONT,     target: A_TRIAL};
                A_PREP:     w = '{op: OP_PREP,    cond: C_NEVER,    target: A_WAIT};
                A_CHK_DIV:  w = '{op: OP_NOP,     cond: C_C_NONPOS, target: A_SAT_MAX};
                A_MUL1:     w = '{op: OP_MUL1,    cond: C_NEVER,    target: A_WAIT};
                A_MUL2:     w = '{op: OP_MUL2,    cond: C_NEVER,    target: A_WAIT};
                A_DIV_GO:   w = '{op: OP_DIV_GO,  cond: C_NEVER,    target: A_WAIT};
                A_DIV_WAIT: w = '{op: OP_NOP,     cond: C_DIV_BUSY, target: A_DIV_WAIT};
                A_FINISH:   w = '{op: OP_FINISH,  cond: C_ALWAYS,   target: A_EMIT};
                A_EMIT:     w = '{op: OP_EMIT,    cond: C_ALWAYS,   target: A_WAIT};
                A_START:    w = '{op: OP_START,   cond: C_ALWAYS,   target: A_EMIT};
                A_IGNORE:   w = '{op: OP_IGNORE,  cond: C_ALWAYS,   target: A_EMIT};
                A_TEST:     w = '{op: OP_TEST,    cond: C_ALWAYS,   target: A_EMIT};
                A_TRIAL:    w = '{op: OP_TRIAL,   cond: C_ALWAYS,   target: A_EMIT};
                A_SAT_MAX:  w = '{op: OP_SAT_MAX, cond: C_ALWAYS,   target: A_EMIT};
                default:    w = '{op: OP_NOP,     cond: C_ALWAYS,   target: A_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

FILE: design/aes_div.sv
// Iterative restoring divider for the exposure extrapolation, one quotient
// bit per cycle. Self-contained; no package dependencies.
`timescale 1ns / 1ps

module aes_div #(
    parameter int DVD_W = 33,
    parameter int DVS_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_trial;
    logic             w_fits;
    logic [DVS_W:0]   w_diff;

    // Bring down the next dividend bit and try the subtraction.
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: design/auto_exposure_search.sv
// Auto exposure search: one item at a time under a microcoded sequencer.
// An extrapolated final time waits on the one-bit-per-cycle divider (dividend
// width 33 at the default FULL_SCALE). The next item is accepted once the
// sequencer is back at its wait step. Synchronous active-low reset restores
// register defaults.
`timescale 1ns / 1ps

module auto_exposure_search
    import aes_pkg::*;
#(
    parameter int FULL_SCALE = 16384
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic signed [16:0] i_requested_time,
    input  logic signed [16:0] i_zenith_time,
    input  logic [15:0]        i_scan_peak,
    input  logic               i_scan_failed,
    // Result output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_exposure_ms,
    output logic signed [16:0] o_recorded_time,
    // Configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    // Widths that follow from the full scale.
    localparam int FS_W   = $clog2(FULL_SCALE + 1);
    localparam int AM_W   = (FS_W > 16) ? FS_W : 16;
    localparam int P1_W   = 11 + AM_W;
    localparam int P2_W   = P1_W + 16;
    localparam int DVD_W  = P2_W - FRAC_BITS;
    localparam int TW     = DVD_W + 2;
    localparam int NT_W   = 11 + FS_W;
    localparam int CMP_W  = (NT_W > 16 + FRAC_BITS) ? NT_W : 16 + FRAC_BITS;

    localparam logic [FS_W-1:0] FS_VEC   = FS_W'(FULL_SCALE);
    localparam logic [PK_W-1:0] LOW_LIM  = PK_W'(LOW_PCT * FULL_SCALE);
    localparam logic [PK_W-1:0] HIGH_LIM = PK_W'(HIGH_PCT * FULL_SCALE);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TEST,
        PH_SEARCH
    } t_phase;

    // Sequencer and model state.
    t_addr       r_pc,        n_pc;
    t_phase      r_phase,     n_phase;
    logic [15:0] r_noise,     n_noise;
    logic [15:0] r_low,       n_low;
    logic [15:0] r_high,      n_high;
    logic [15:0] r_trial,     n_trial;
    logic [15:0] r_last_peak, n_last_peak;
    logic [16:0] r_saved,     n_saved;
    logic        r_cont,      n_cont;
    logic [15:0] r_max,       n_max;
    logic [15:0] r_min,       n_min;
    logic [10:0] r_target,    n_target;
    logic        r_out_valid, n_out_valid;

    // Latched input beat.
    logic        r_func,      n_func;
    logic [16:0] r_req,       n_req;
    logic [16:0] r_zen,       n_zen;
    logic [15:0] r_peak,      n_peak;
    logic        r_failed,    n_failed;

    // Staged result and output register.
    logic [1:0]  r_res_kind,  n_res_kind;
    logic [15:0] r_res_exp,   n_res_exp;
    logic [16:0] r_res_rec,   n_res_rec;
    logic [1:0]  r_out_kind,  n_out_kind;
    logic [15:0] r_out_exp,   n_out_exp;
    logic [16:0] r_out_rec,   n_out_rec;

    // Extrapolation datapath.
    logic [AM_W-1:0] r_a_mag,    n_a_mag;
    logic [15:0]     r_b_mag,    n_b_mag;
    logic            r_neg,      n_neg;
    logic [15:0]     r_c_mag,    n_c_mag;
    logic            r_c_nonpos, n_c_nonpos;
    logic [P1_W-1:0] r_p1,       n_p1;
    logic [P2_W-1:0] r_p2,       n_p2;

    t_uword      w_word;
    logic        w_take;
    logic        w_hold;
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_div_start;
    logic        w_div_busy;
    logic [DVD_W-1:0] w_quo;

    // Start item values.
    logic        w_req_pos;
    logic        w_req_zero;
    logic [16:0] w_zen_mag;
    logic [15:0] w_zen_sat;
    logic [15:0] w_zen_t;

    // Test scan values.
    logic [CMP_W-1:0] w_pk_scaled;
    logic [CMP_W-1:0] w_noise_lim;
    logic             w_noisy;

    // Search step values.
    logic [15:0]     w_s_peak;
    logic [PK_W-1:0] w_s_pk100;
    logic            w_too_low;
    logic            w_too_high;
    logic            w_at_max;
    logic [16:0]     w_dbl;
    logic [15:0]     w_dbl_sat;
    logic [16:0]     w_sum_ht;
    logic [16:0]     w_sum_tl;
    logic [15:0]     w_s_low;
    logic [15:0]     w_s_high;
    logic [15:0]     w_s_trial;
    logic [16:0]     w_s_gap;
    logic            w_s_cont;

    // Preparation values.
    logic [AM_W:0]   w_a_s;
    logic [AM_W:0]   w_a_neg_s;
    logic [16:0]     w_b_s;
    logic [16:0]     w_b_neg_s;
    logic [16:0]     w_c_s;

    // Final clamp values.
    logic [TW-1:0]   w_q_ext;
    logic [TW-1:0]   w_t_s;
    logic            w_gt_max;
    logic            w_lt_min;
    logic [15:0]     w_fin_t;

    // Divider for the extrapolated time.
    aes_div #(
        .DVD_W (DVD_W),
        .DVS_W (16)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_p2[P2_W-1:FRAC_BITS]),
        .i_divisor  (r_c_mag),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // Control word fetch and handshakes.
    assign w_word      = aes_rom(r_pc);
    assign o_in_stall  = (r_pc != A_WAIT);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign w_hold      = (w_word.op == OP_EMIT) && r_out_valid && i_out_stall;
    assign w_div_start = (w_word.op == OP_DIV_GO);
    assign o_cfg_ready = 1'b1;

    // Start item: fixed request, or zenith magnitude with saturation.
    assign w_req_pos  = !r_req[16] && (r_req != 17'd0);
    assign w_req_zero = (r_req == 17'd0);
    assign w_zen_mag  = r_zen[16] ? (17'd0 - r_zen) : r_zen;
    assign w_zen_sat  = w_zen_mag[16] ? 16'hFFFF : w_zen_mag[15:0];
    assign w_zen_t    = (w_zen_sat == 16'd1) ? r_max : w_zen_sat;

    // Test scan: noise cutoff at target fraction of full scale.
    assign w_pk_scaled = CMP_W'({r_peak, {FRAC_BITS{1'b0}}});
    assign w_noise_lim = CMP_W'(r_target * FS_VEC);
    assign w_noisy     = (w_pk_scaled > w_noise_lim);

    // Search step: window test and bound update.
    assign w_s_peak   = r_failed ? r_last_peak : r_peak;
    assign w_s_pk100  = PK_W'(w_s_peak) * PCT_SCALE;
    assign w_too_low  = (w_s_pk100 < LOW_LIM);
    assign w_too_high = (w_s_pk100 > HIGH_LIM);
    assign w_at_max   = (r_trial >= r_max);
    assign w_dbl      = {r_high, 1'b0};
    assign w_dbl_sat  = w_dbl[16] ? 16'hFFFF : w_dbl[15:0];
    assign w_sum_ht   = {1'b0, r_high} + {1'b0, r_trial};
    assign w_sum_tl   = {1'b0, r_trial} + {1'b0, r_low};

    always_comb begin
        w_s_low   = r_low;
        w_s_high  = r_high;
        w_s_trial = r_trial;
        if (w_too_low) begin
            if (r_high == r_trial) begin
                w_s_low   = r_high;
                w_s_high  = w_dbl_sat;
                w_s_trial = w_dbl_sat;
            end else begin
                w_s_low   = r_trial;
                w_s_trial = w_sum_ht[16:1];
            end
        end else if (w_too_high) begin
            w_s_high  = r_trial;
            w_s_trial = w_sum_tl[16:1];
        end
    end

    assign w_s_gap  = {1'b0, w_s_high} - {1'b0, w_s_low};
    assign w_s_cont = (w_too_low || w_too_high || w_at_max)
                      && !w_s_gap[16] && (w_s_gap >= CLOSE_MS);

    // Extrapolation operands as sign and magnitude.
    assign w_a_s     = (AM_W + 1)'(FULL_SCALE) - (AM_W + 1)'(r_noise);
    assign w_a_neg_s = '0 - w_a_s;
    assign w_b_s     = {1'b0, r_trial} - {1'b0, TEST_SHORT};
    assign w_b_neg_s = 17'd0 - w_b_s;
    assign w_c_s     = {1'b0, r_last_peak} - {1'b0, r_noise};

    // Extrapolated time and clamp.
    assign w_q_ext  = {2'b00, w_quo};
    assign w_t_s    = r_neg ? (TW'(TEST_SHORT) - w_q_ext) : (TW'(TEST_SHORT) + w_q_ext);
    assign w_gt_max = !w_t_s[TW-1] && (w_t_s > TW'(r_max));
    assign w_lt_min = w_t_s[TW-1] || (w_t_s < TW'(r_min));

    always_comb begin
        if (w_gt_max) begin
            w_fin_t = r_max;
        end else if (w_lt_min) begin
            w_fin_t = (r_last_peak < DIM_PEAK) ? r_max : r_min;
        end else begin
            w_fin_t = w_t_s[15:0];
        end
    end

    // Sequencer: next step and datapath operation of the current word.
    always_comb begin
        n_phase     = r_phase;
        n_noise     = r_noise;
        n_low       = r_low;
        n_high      = r_high;
        n_trial     = r_trial;
        n_last_peak = r_last_peak;
        n_saved     = r_saved;
        n_cont      = r_cont;
        n_max       = r_max;
        n_min       = r_min;
        n_target    = r_target;
        n_func      = r_func;
        n_req       = r_req;
        n_zen       = r_zen;
        n_peak      = r_peak;
        n_failed    = r_failed;
        n_res_kind  = r_res_kind;
        n_res_exp   = r_res_exp;
        n_res_rec   = r_res_rec;
        n_out_valid = r_out_valid && !w_out_acc;
        n_out_kind  = r_out_kind;
        n_out_exp   = r_out_exp;
        n_out_rec   = r_out_rec;
        n_a_mag     = r_a_mag;
        n_b_mag     = r_b_mag;
        n_neg       = r_neg;
        n_c_mag     = r_c_mag;
        n_c_nonpos  = r_c_nonpos;
        n_p1        = r_p1;
        n_p2        = r_p2;

        // Jump condition.
        case (w_word.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_INPUT: w_take = !i_in_valid;
            C_START:    w_take = (r_func == FUNC_START);
            C_PH_IDLE:  w_take = (r_phase == PH_IDLE);
            C_PH_TEST:  w_take = (r_phase == PH_TEST);
            C_CONT:     w_take = r_cont;
            C_C_NONPOS: w_take = r_c_nonpos;
            C_DIV_BUSY: w_take = w_div_busy;
            default:    w_take = 1'b0;
        endcase

        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_word.target;
        end else begin
            n_pc = t_addr'(r_pc + 1'b1);
        end

        // Input beat capture.
        if (w_in_acc) begin
            n_func   = i_func;
            n_req    = i_requested_time;
            n_zen    = i_zenith_time;
            n_peak   = i_scan_peak;
            n_failed = i_scan_failed;
        end

        // Configuration writes.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_EXPOSURE: n_max    = i_cfg_data;
                CFG_MIN_EXPOSURE: n_min    = i_cfg_data;
                CFG_TARGET_FRAC:  n_target = i_cfg_data[10:0];
                default: ;
            endcase
        end

        // Datapath operation.
        case (w_word.op)
            OP_START: begin
                if (w_req_pos) begin
                    n_phase    = PH_IDLE;
                    n_res_kind = KIND_FINAL;
                    n_res_exp  = r_req[15:0];
                    n_res_rec  = r_req;
                end else if (w_req_zero) begin
                    n_phase    = PH_IDLE;
                    n_res_kind = KIND_FINAL;
                    n_res_exp  = w_zen_t;
                    n_res_rec  = 17'd0 - {1'b0, w_zen_t};
                end else begin
                    n_saved    = r_req;
                    n_phase    = PH_TEST;
                    n_res_kind = KIND_SCAN;
                    n_res_exp  = TEST_SHORT;
                    n_res_rec  = 17'd0;
                end
            end
            OP_IGNORE: begin
                n_res_kind = KIND_IGNORED;
                n_res_exp  = 16'd0;
                n_res_rec  = 17'd0;
            end
            OP_TEST: begin
                if (r_failed) begin
                    n_phase    = PH_IDLE;
                    n_res_kind = KIND_FINAL;
                    n_res_exp  = FAIL_TIME;
                    n_res_rec  = r_saved;
                end else begin
                    n_noise     = r_peak;
                    n_last_peak = r_peak;
                    if (w_noisy) begin
                        n_phase    = PH_IDLE;
                        n_res_kind = KIND_FINAL;
                        n_res_exp  = TEST_SHORT;
                        n_res_rec  = 17'd0 - {1'b0, TEST_SHORT};
                    end else begin
                        n_low      = TEST_SHORT;
                        n_high     = TEST_LONG;
                        n_trial    = TEST_LONG;
                        n_phase    = PH_SEARCH;
                        n_res_kind = KIND_SCAN;
                        n_res_exp  = TEST_LONG;
                        n_res_rec  = 17'd0;
                    end
                end
            end
            OP_SEARCH: begin
                n_last_peak = w_s_peak;
                n_low       = w_s_low;
                n_high      = w_s_high;
                n_trial     = w_s_trial;
                n_cont      = w_s_cont;
            end
            OP_TRIAL: begin
                n_res_kind = KIND_SCAN;
                n_res_exp  = r_trial;
                n_res_rec  = 17'd0;
            end
            OP_PREP: begin
                n_phase    = PH_IDLE;
                n_a_mag    = w_a_s[AM_W] ? w_a_neg_s[AM_W-1:0] : w_a_s[AM_W-1:0];
                n_b_mag    = w_b_s[16] ? w_b_neg_s[15:0] : w_b_s[15:0];
                n_neg      = w_a_s[AM_W] ^ w_b_s[16];
                n_c_mag    = w_c_s[15:0];
                n_c_nonpos = w_c_s[16] || (w_c_s == 17'd0);
            end
            OP_SAT_MAX: begin
                n_res_kind = KIND_FINAL;
                n_res_exp  = r_max;
                n_res_rec  = 17'd0 - {1'b0, r_max};
            end
            OP_MUL1: begin
                n_p1 = P1_W'(r_target) * P1_W'(r_a_mag);
            end
            OP_MUL2: begin
                n_p2 = P2_W'(r_p1) * P2_W'(r_b_mag);
            end
            OP_FINISH: begin
                n_res_kind = KIND_FINAL;
                n_res_exp  = w_fin_t;
                n_res_rec  = 17'd0 - {1'b0, w_fin_t};
            end
            OP_EMIT: begin
                if (!w_hold) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_exp   = r_res_exp;
                    n_out_rec   = r_res_rec;
                end
            end
            default: ;
        endcase
    end

    // Control state, model state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= A_WAIT;
            r_phase     <= PH_IDLE;
            r_noise     <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_trial     <= '0;
            r_last_peak <= '0;
            r_saved     <= '0;
            r_cont      <= 1'b0;
            r_max       <= MAX_EXPOSURE_RST;
            r_min       <= MIN_EXPOSURE_RST;
            r_target    <= TARGET_FRAC_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_phase     <= n_phase;
            r_noise     <= n_noise;
            r_low       <= n_low;
            r_high      <= n_high;
            r_trial     <= n_trial;
            r_last_peak <= n_last_peak;
            r_saved     <= n_saved;
            r_cont      <= n_cont;
            r_max       <= n_max;
            r_min       <= n_min;
            r_target    <= n_target;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_req      <= n_req;
        r_zen      <= n_zen;
        r_peak     <= n_peak;
        r_failed   <= n_failed;
        r_res_kind <= n_res_kind;
        r_res_exp  <= n_res_exp;
        r_res_rec  <= n_res_rec;
        r_out_kind <= n_out_kind;
        r_out_exp  <= n_out_exp;
        r_out_rec  <= n_out_rec;
        r_a_mag    <= n_a_mag;
        r_b_mag    <= n_b_mag;
        r_neg      <= n_neg;
        r_c_mag    <= n_c_mag;
        r_c_nonpos <= n_c_nonpos;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_exposure_ms   = r_out_exp;
    assign o_recorded_time = r_out_rec;

endmodule

FILE: test/auto_exposure_search_checker.sv
// Checker for the auto exposure search block: watches the item, result and
// configuration channels, predicts every result beat and compares it.
// Depends on aes_pkg for the field codes, register indexes and fixed times.
`timescale 1ns / 1ps

module auto_exposure_search_checker
    import aes_pkg::*;
#(
    parameter int FULL_SCALE = 16384
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item channel as seen at the block's input
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_func,
    input  logic signed [16:0] i_requested_time,
    input  logic signed [16:0] i_zenith_time,
    input  logic [15:0]        i_scan_peak,
    input  logic               i_scan_failed,
    // Result channel as seen at the block's output
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_kind,
    input  logic [15:0]        i_exposure_ms,
    input  logic signed [16:0] i_recorded_time,
    // Configuration write channel
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // Status handed to the testbench top
    output int                 o_fail_count,
    output int                 o_pending,
    output logic               o_calibrating
);

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        exposure_ms;
        logic signed [16:0] recorded_time;
    } exposure_beat_t;

    typedef enum logic [1:0] {
        CAL_IDLE,
        CAL_TEST,
        CAL_SEARCH
    } cal_phase_t;

    // Shadow copy of the registers and of the calibration state.
    logic [15:0]        max_exposure;
    logic [15:0]        min_exposure;
    logic [10:0]        target_q10;
    cal_phase_t         cal_phase;
    logic [15:0]        noise_level;
    logic [15:0]        low_bound;
    logic [15:0]        high_bound;
    logic [15:0]        trial_ms;
    logic [15:0]        last_peak;
    logic signed [16:0] saved_request;

    exposure_beat_t     expected_q[$];
    exposure_beat_t     want;
    int                 fail_total = 0;

    // Extrapolated final time from the last search scan, clamped to the limits.
    function automatic logic [15:0] extrapolated_ms(input logic [15:0] peak);
        longint span;
        longint rise;
        longint height;
        longint t;
        span   = longint'(FULL_SCALE) - longint'(noise_level);
        rise   = longint'(trial_ms) - longint'(TEST_SHORT);
        height = longint'(peak) - longint'(noise_level);
        // A peak at or below the noise floor gives no usable slope.
        if (height <= 0)
            return max_exposure;
        t = (longint'(target_q10) * span * rise) / (longint'(1024) * height)
            + longint'(TEST_SHORT);
        if (t > longint'(max_exposure))
            return max_exposure;
        if (t < longint'(min_exposure))
            return (peak < DIM_PEAK) ? max_exposure : min_exposure;
        return t[15:0];
    endfunction

    // Works out the result beat of one accepted item and queues it.
    task automatic predict_result(
        input logic               func,
        input logic signed [16:0] req,
        input logic signed [16:0] zen,
        input logic [15:0]        peak_in,
        input logic               failed
    );
        exposure_beat_t r;
        longint         mag;
        logic [15:0]    peak;
        logic           too_low;
        logic           too_high;
        logic           keep_searching;
        int             mid;
        r.kind          = KIND_IGNORED;
        r.exposure_ms   = '0;
        r.recorded_time = '0;
        peak            = peak_in;
        keep_searching  = 1'b0;
        if (func == FUNC_START) begin
            // A start always abandons whatever calibration was running.
            cal_phase = CAL_IDLE;
            r.kind    = KIND_FINAL;
            if (req > 0) begin
                r.exposure_ms   = req[15:0];
                r.recorded_time = req;
            end else if (req == 0) begin
                mag = (zen < 0) ? -longint'(zen) : longint'(zen);
                if (mag > 65535)
                    mag = 65535;
                if (mag == 1)
                    mag = longint'(max_exposure);
                r.exposure_ms   = mag[15:0];
                r.recorded_time = -mag;
            end else begin
                saved_request = req;
                cal_phase     = CAL_TEST;
                r.kind        = KIND_SCAN;
                r.exposure_ms = TEST_SHORT;
            end
        end else if (cal_phase == CAL_TEST) begin
            r.kind = KIND_FINAL;
            if (failed) begin
                cal_phase       = CAL_IDLE;
                r.exposure_ms   = FAIL_TIME;
                r.recorded_time = saved_request;
            end else begin
                noise_level = peak;
                last_peak   = peak;
                if (longint'(peak) * 1024 > longint'(target_q10) * FULL_SCALE) begin
                    // Too noisy to calibrate: settle on the short test time.
                    cal_phase       = CAL_IDLE;
                    r.exposure_ms   = TEST_SHORT;
                    r.recorded_time = -longint'(TEST_SHORT);
                end else begin
                    low_bound     = TEST_SHORT;
                    high_bound    = TEST_LONG;
                    trial_ms      = TEST_LONG;
                    cal_phase     = CAL_SEARCH;
                    r.kind        = KIND_SCAN;
                    r.exposure_ms = TEST_LONG;
                end
            end
        end else if (cal_phase == CAL_SEARCH) begin
            // A timed-out scan reuses the previous peak.
            if (failed)
                peak = last_peak;
            last_peak = peak;
            too_low   = longint'(peak) * 100 < longint'(LOW_PCT) * FULL_SCALE;
            too_high  = longint'(peak) * 100 > longint'(HIGH_PCT) * FULL_SCALE;
            if (too_low || too_high || trial_ms >= max_exposure) begin
                if (too_low) begin
                    if (high_bound == trial_ms) begin
                        // Still climbing: double, saturating at the top.
                        low_bound  = high_bound;
                        high_bound = (high_bound > 16'h7FFF) ? 16'hFFFF
                                                             : {high_bound[14:0], 1'b0};
                        trial_ms   = high_bound;
                    end else begin
                        low_bound = trial_ms;
                        mid       = (int'(high_bound) + int'(low_bound)) / 2;
                        trial_ms  = mid;
                    end
                end else if (too_high) begin
                    high_bound = trial_ms;
                    mid        = (int'(high_bound) + int'(low_bound)) / 2;
                    trial_ms   = mid;
                end
                if (int'(high_bound) - int'(low_bound) >= int'(CLOSE_MS))
                    keep_searching = 1'b1;
            end
            if (keep_searching) begin
                r.kind        = KIND_SCAN;
                r.exposure_ms = trial_ms;
            end else begin
                cal_phase       = CAL_IDLE;
                r.kind          = KIND_FINAL;
                r.exposure_ms   = extrapolated_ms(peak);
                r.recorded_time = -longint'(r.exposure_ms);
            end
        end
        expected_q.push_back(r);
    endtask

    // Channel monitor: result beats are checked before the item of the same
    // edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_exposure  = MAX_EXPOSURE_RST;
            min_exposure  = MIN_EXPOSURE_RST;
            target_q10    = TARGET_FRAC_RST;
            cal_phase     = CAL_IDLE;
            noise_level   = '0;
            low_bound     = '0;
            high_bound    = '0;
            trial_ms      = '0;
            last_peak     = '0;
            saved_request = '0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result beat: kind %0d, exposure_ms %0d, recorded_time %0d",
                           i_kind, i_exposure_ms, i_recorded_time);
                    fail_total++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_kind !== want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, i_kind);
                        fail_total++;
                    end
                    if (i_exposure_ms !== want.exposure_ms) begin
                        $error("exposure_ms mismatch: expected %0d, actual %0d",
                               want.exposure_ms, i_exposure_ms);
                        fail_total++;
                    end
                    if (i_recorded_time !== want.recorded_time) begin
                        $error("recorded_time mismatch: expected %0d, actual %0d",
                               want.recorded_time, i_recorded_time);
                        fail_total++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_EXPOSURE: max_exposure = i_cfg_data;
                    CFG_MIN_EXPOSURE: min_exposure = i_cfg_data;
                    CFG_TARGET_FRAC:  target_q10   = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_result(i_func, i_requested_time, i_zenith_time, i_scan_peak,
                               i_scan_failed);
        end
        o_pending     <= expected_q.size();
        o_calibrating <= (cal_phase != CAL_IDLE);
        o_fail_count  <= fail_total;
    end

endmodule

FILE: test/tb_auto_exposure_search.sv
// Testbench top for the auto exposure search block: drives items, result
// stalls and register writes, and gives the verdict from the checker's count.
// Depends on aes_pkg, auto_exposure_search and auto_exposure_search_checker.
`timescale 1ns / 1ps

module tb_auto_exposure_search;
    import aes_pkg::*;

    localparam int FULL_SCALE   = 16384;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 250;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic signed [16:0] requested_time;
    logic signed [16:0] zenith_time;
    logic [15:0]        scan_peak;
    logic               scan_failed;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         kind;
    logic [15:0]        exposure_ms;
    logic signed [16:0] recorded_time;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    int                 fail_count;
    int                 pending;
    logic               calibrating;
    int                 sent_items = 0;
    int                 cycle_count = 0;
    bit                 quiet = 1'b0;
    bit                 long_hold = 1'b0;

    logic [15:0]        max_set[5];
    logic [15:0]        min_set[5];
    logic [15:0]        target_set[5];

    auto_exposure_search #(
        .FULL_SCALE(FULL_SCALE)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_func          (func),
        .i_requested_time(requested_time),
        .i_zenith_time   (zenith_time),
        .i_scan_peak     (scan_peak),
        .i_scan_failed   (scan_failed),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_kind          (kind),
        .o_exposure_ms   (exposure_ms),
        .o_recorded_time (recorded_time),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    auto_exposure_search_checker #(
        .FULL_SCALE(FULL_SCALE)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_func          (func),
        .i_requested_time(requested_time),
        .i_zenith_time   (zenith_time),
        .i_scan_peak     (scan_peak),
        .i_scan_failed   (scan_failed),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_kind          (kind),
        .i_exposure_ms   (exposure_ms),
        .i_recorded_time (recorded_time),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_calibrating   (calibrating)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request, and no
    // stalls at all once the run goes quiet.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold = 1'b0;
                out_stall = 1'b0;
            end else begin
                out_stall = !quiet && ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end
        end
    end

    // Random exposure value of either sign within the field's range.
    function automatic logic signed [16:0] random_ms();
        int v;
        v = $urandom_range(0, 65535);
        return ($urandom_range(0, 1) == 1) ? -v : v;
    endfunction

    // Offers one item beat and returns at the falling edge after acceptance,
    // with valid still high. A random gap may come first.
    task automatic send_item(
        input logic               f,
        input logic signed [16:0] req,
        input logic signed [16:0] zen,
        input logic [15:0]        peak,
        input logic               failed
    );
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid       = 1'b0;
            requested_time = random_ms();
            scan_peak      = $urandom_range(0, 65535);
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_valid       = 1'b1;
        func           = f;
        requested_time = req;
        zenith_time    = zen;
        scan_peak      = peak;
        scan_failed    = failed;
        do
            @(posedge i_clk);
        while (in_stall);
        @(negedge i_clk);
        sent_items++;
    endtask

    // Unstructured item: any function, any request, any scan report.
    task automatic send_noise();
        logic signed [16:0] req;
        logic signed [16:0] zen;
        case ($urandom_range(0, 5))
            0, 1:    req = $urandom_range(1, 65535);
            2:       req = 0;
            3, 4:    req = -int'($urandom_range(1, 65535));
            default: req = random_ms();
        endcase
        zen = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? 1 : -1)
                                          : random_ms();
        send_item($urandom_range(0, 1), req, zen, $urandom_range(0, 65535),
                  $urandom_range(0, 1));
    endtask

    // One calibration: automatic start, test scan, then up to 40 search scans while
    // the search runs, with a random early stop and a random bias towards dim or bright peaks.
    task automatic run_calibration();
        int          steps;
        int          low_w;
        int          r;
        logic [15:0] peak;
        logic        failed;
        send_item(FUNC_START, -int'($urandom_range(1, 65535)), random_ms(),
                  $urandom_range(0, 65535), $urandom_range(0, 1));
        r      = $urandom_range(0, 19);
        failed = (r == 0);
        if (r <= 2)
            peak = $urandom_range(0, 65535);
        else if (r <= 6)
            peak = $urandom_range(3000, 12000);
        else
            peak = $urandom_range(0, 3000);
        send_item(FUNC_RESULT, random_ms(), random_ms(), peak, failed);
        case ($urandom_range(0, 2))
            0:       low_w = 90;
            1:       low_w = 55;
            default: low_w = 25;
        endcase
        steps = 0;
        while (calibrating && steps < 40 && $urandom_range(0, 59) != 0) begin
            r = $urandom_range(0, 99);
            if (r < low_w)
                peak = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 199)
                                                   : $urandom_range(0, 4915);
            else if (r < low_w + 12)
                peak = $urandom_range(4916, 14745);
            else
                peak = $urandom_range(14746, 65535);
            failed = ($urandom_range(0, 19) == 0);
            send_item(FUNC_RESULT, random_ms(), random_ms(), peak, failed);
            steps++;
        end
    endtask

    // Stops offering items and waits until the block has nothing in hand.
    task automatic await_idle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One register write beat; valid is left high for a following write.
    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do
            @(posedge i_clk);
        while (!cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input int n);
        await_idle();
        write_reg(CFG_MAX_EXPOSURE, max_set[n]);
        write_reg(CFG_MIN_EXPOSURE, min_set[n]);
        write_reg(CFG_TARGET_FRAC, target_set[n]);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int goal;
        in_valid       = 1'b0;
        func           = FUNC_START;
        requested_time = '0;
        zenith_time    = '0;
        scan_peak      = '0;
        scan_failed    = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_MAX_EXPOSURE;
        cfg_data       = '0;

        // Settings for the random phases, the extremes among them.
        max_set[0] = $urandom_range(500, 20000);
        min_set[0] = $urandom_range(0, 400);
        target_set[0] = $urandom_range(300, 1000);
        max_set[1] = 16'd65535; min_set[1] = 16'd0;     target_set[1] = 16'd1024;
        max_set[2] = 16'd1;     min_set[2] = 16'd65535; target_set[2] = 16'd0;
        max_set[3] = 16'd65535; min_set[3] = 16'd65535; target_set[3] = 16'd512;
        max_set[4] = 16'd400;   min_set[4] = 16'd30;
        target_set[4] = $urandom_range(0, 1024);

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset settings.
        // Fixed requests and zenith records at the edges of their range.
        send_item(FUNC_START, 65535, 0, 0, 1'b0);
        send_item(FUNC_START, 1, -65535, 65535, 1'b1);
        send_item(FUNC_START, 0, 1, 0, 1'b0);
        send_item(FUNC_START, 0, -1, 0, 1'b0);
        send_item(FUNC_START, 0, 65535, 0, 1'b0);
        send_item(FUNC_START, 0, -65535, 0, 1'b0);
        send_item(FUNC_START, 0, 0, 0, 1'b0);
        // Scan report with no calibration running.
        send_item(FUNC_RESULT, 65535, 65535, 65535, 1'b1);
        // Test scan that times out.
        send_item(FUNC_START, -65535, 0, 0, 1'b0);
        send_item(FUNC_RESULT, 0, 0, 0, 1'b1);
        // Test scan too noisy to go on.
        send_item(FUNC_START, -1, 0, 0, 1'b0);
        send_item(FUNC_RESULT, 0, 0, 65535, 1'b0);
        // Clean calibration landing on the lower edge of the window.
        send_item(FUNC_START, -5, 0, 0, 1'b0);
        send_item(FUNC_RESULT, 0, 0, 0, 1'b0);
        send_item(FUNC_RESULT, 0, 0, 4916, 1'b0);
        // Search peak below the noise floor.
        send_item(FUNC_START, -7, 0, 0, 1'b0);
        send_item(FUNC_RESULT, 0, 0, 9000, 1'b0);
        send_item(FUNC_RESULT, 0, 0, 6000, 1'b0);
        // Failed search scan, doubling, bisection, then a start mid-search.
        send_item(FUNC_START, -9, 0, 0, 1'b0);
        send_item(FUNC_RESULT, 0, 0, 100, 1'b0);
        send_item(FUNC_RESULT, 0, 0, 50000, 1'b1);
        send_item(FUNC_RESULT, 0, 0, 14746, 1'b0);
        send_item(FUNC_RESULT, 0, 0, 4915, 1'b0);
        send_item(FUNC_START, 300, 0, 0, 1'b0);

        // Random phases, one per register setting.
        for (int n = 0; n < 5; n++) begin
            apply_settings(n);
            if (n == 0) begin
                // Hold results back while items keep coming.
                long_hold = 1'b1;
                repeat (8) send_noise();
            end
            goal = sent_items + PHASE_ITEMS;
            while (sent_items < goal) begin
                if (n == 4 && sent_items > goal - PHASE_ITEMS / 2)
                    quiet = 1'b1;
                if ($urandom_range(0, 9) < 6)
                    run_calibration();
                else
                    send_noise();
            end
        end

        await_idle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
